@@ design/uart_pkg.sv @@
package uart_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 64;
  localparam int unsigned DATA_BITS      = 8;
  localparam int unsigned TICK_W         = 16;
  localparam int unsigned COUNT_W        = 7;

  localparam logic [TICK_W-1:0] RESET_BIT_TICKS = 16'd416;

  typedef enum logic [1:0] {
    DROP_NONE = 2'd0,
    DROP_STOP = 2'd1,
    DROP_FULL = 2'd2
  } drop_t;

  typedef struct packed {
    logic                 rx_line;
    logic                 tx_write;
    logic [DATA_BITS-1:0] tx_data;
    logic                 rx_read;
  } in_item_t;

  typedef struct packed {
    logic                 tx_line;
    logic                 tx_busy;
    logic                 tx_accepted;
    logic [DATA_BITS-1:0] rx_data;
    logic                 rx_data_valid;
    logic [COUNT_W-1:0]   rx_fifo_count;
    logic [1:0]           rx_drop;
  } out_item_t;

  typedef struct packed {
    logic                 push;
    logic [DATA_BITS-1:0] data;
  } rx_push_t;

  // A wait that would load as zero loads as one.
  function automatic logic [TICK_W-1:0] load_wait(input logic [TICK_W-1:0] v);
    load_wait = (v == '0) ? TICK_W'(1) : v;
  endfunction

endpackage

@@ design/uart_rx.sv @@
module uart_rx (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             line,
  input  logic [uart_pkg::TICK_W-1:0]      bit_ticks,
  input  logic                             fifo_full,
  output uart_pkg::rx_push_t               push,
  output uart_pkg::drop_t                  drop
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_DATA,
    PH_STOP
  } phase_t;

  phase_t                             phase_r, phase_nxt;
  logic [uart_pkg::DATA_BITS-1:0]     shift_r, shift_nxt;
  logic [3:0]                         bits_r, bits_nxt;
  logic [uart_pkg::TICK_W-1:0]        wait_r, wait_nxt, wait_dec;
  logic                               line_prev_r;

  assign wait_dec = (wait_r != '0) ? wait_r - uart_pkg::TICK_W'(1) : '0;

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    wait_nxt  = wait_r;
    push.push = 1'b0;
    push.data = shift_r;
    drop      = uart_pkg::DROP_NONE;
    case (phase_r)
      PH_IDLE: begin
        if (line_prev_r && !line) begin
          phase_nxt = PH_START;
          wait_nxt  = uart_pkg::load_wait(bit_ticks >> 1);
        end
      end
      PH_START: begin
        wait_nxt = wait_dec;
        if (wait_dec == '0) begin
          if (!line) begin
            phase_nxt = PH_DATA;
            bits_nxt  = '0;
            shift_nxt = '0;
            wait_nxt  = uart_pkg::load_wait(bit_ticks);
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_DATA: begin
        wait_nxt = wait_dec;
        if (wait_dec == '0) begin
          shift_nxt = shift_r | ({{(uart_pkg::DATA_BITS-1){1'b0}}, line} << bits_r[2:0]);
          bits_nxt  = bits_r + 4'd1;
          if (bits_nxt >= 4'd8) begin
            phase_nxt = PH_STOP;
          end
          wait_nxt = uart_pkg::load_wait(bit_ticks);
        end
      end
      PH_STOP: begin
        wait_nxt = wait_dec;
        if (wait_dec == '0) begin
          if (line) begin
            if (fifo_full) begin
              drop = uart_pkg::DROP_FULL;
            end else begin
              push.push = 1'b1;
            end
          end else begin
            drop = uart_pkg::DROP_STOP;
          end
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      shift_r     <= '0;
      bits_r      <= '0;
      wait_r      <= '0;
      line_prev_r <= 1'b1;
    end else if (en) begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      bits_r      <= bits_nxt;
      wait_r      <= wait_nxt;
      line_prev_r <= line;
    end
  end

endmodule

@@ design/uart_fifo.sv @@
module uart_fifo #(
  parameter int unsigned DEPTH = uart_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           pop_req,
  input  uart_pkg::rx_push_t             push,
  output logic                           pop,
  output logic                           full_after_pop,
  output logic [$clog2(DEPTH+1)-1:0]     count,
  output logic [uart_pkg::DATA_BITS-1:0] rd_q
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [uart_pkg::DATA_BITS-1:0] mem [DEPTH];
  logic [AW-1:0]                  head_r, tail_r;
  logic [CW-1:0]                  fill_r, fill_after_pop, fill_nxt;
  logic                           do_push;

  assign pop            = pop_req && (fill_r != '0);
  assign fill_after_pop = fill_r - CW'(pop);
  assign full_after_pop = (fill_after_pop >= CW'(DEPTH));
  assign do_push        = push.push && !full_after_pop;
  assign fill_nxt       = fill_after_pop + CW'(do_push);
  assign count          = fill_nxt;

  always_ff @(posedge clk) begin
    if (en && do_push) begin
      mem[head_r] <= push.data;
    end
  end

  // The read takes the old contents when head meets tail on a full FIFO,
  // which matches pop-before-push ordering.
  always_ff @(posedge clk) begin
    if (en && pop) begin
      rd_q <= mem[tail_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else if (en) begin
      if (do_push) begin
        head_r <= (head_r == AW'(DEPTH-1)) ? '0 : head_r + AW'(1);
      end
      if (pop) begin
        tail_r <= (tail_r == AW'(DEPTH-1)) ? '0 : tail_r + AW'(1);
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

@@ design/uart_tx.sv @@
module uart_tx (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           write,
  input  logic [uart_pkg::DATA_BITS-1:0] data,
  input  logic [uart_pkg::TICK_W-1:0]    bit_ticks,
  output logic                           line_nxt,
  output logic                           busy_nxt,
  output logic                           accepted
);

  localparam logic [3:0] STEP_START = 4'd0;
  localparam logic [3:0] STEP_STOP  = 4'd9;
  localparam logic [3:0] STEP_DONE  = 4'd10;

  logic [3:0]                     step_r, step_nxt, step_m1;
  logic [uart_pkg::DATA_BITS-1:0] hold_r, hold_nxt;
  logic                           flag_r;
  logic [uart_pkg::TICK_W-1:0]    wait_r, wait_nxt, wait_dec;
  logic                           level_r;

  assign wait_dec = (wait_r != '0) ? wait_r - uart_pkg::TICK_W'(1) : '0;
  assign step_m1  = step_r - 4'd1;

  always_comb begin
    step_nxt = step_r;
    hold_nxt = hold_r;
    busy_nxt = flag_r;
    wait_nxt = wait_r;
    line_nxt = level_r;
    accepted = 1'b0;
    if (flag_r) begin
      wait_nxt = wait_dec;
      if (wait_dec == '0) begin
        wait_nxt = uart_pkg::load_wait(bit_ticks);
        case (step_r) inside
          STEP_START: begin
            line_nxt = 1'b0;
            step_nxt = 4'd1;
          end
          [4'd1:4'd8]: begin
            line_nxt = hold_r[step_m1[2:0]];
            step_nxt = step_r + 4'd1;
          end
          STEP_STOP: begin
            line_nxt = 1'b1;
            step_nxt = STEP_DONE;
          end
          default: begin
            busy_nxt = 1'b0;
            step_nxt = STEP_START;
          end
        endcase
      end
    end else if (write) begin
      hold_nxt = data;
      step_nxt = STEP_START;
      busy_nxt = 1'b1;
      wait_nxt = uart_pkg::load_wait(bit_ticks);
      accepted = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_START;
      hold_r  <= '0;
      flag_r  <= 1'b0;
      wait_r  <= '0;
      level_r <= 1'b1;
    end else if (en) begin
      step_r  <= step_nxt;
      hold_r  <= hold_nxt;
      flag_r  <= busy_nxt;
      wait_r  <= wait_nxt;
      level_r <= line_nxt;
    end
  end

endmodule

@@ design/uart_8n1_transceiver_fifo_core.sv @@
// Pipeline: a result beat is registered first in stage one, alongside the
// receive FIFO read register, and then in the output register.
// Throughput: one tick beat per cycle when the output is not stalled; the
// line state, counters and FIFO pointers update in the cycle of acceptance.
// Reset (synchronous, rst_n low): bit_ticks returns to 416, both channels go
// empty, receiver and transmitter go idle; FIFO storage is not cleared.
module uart_8n1_transceiver_fifo_core #(
  parameter int unsigned FIFO_DEPTH = uart_pkg::FIFO_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  uart_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output uart_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [uart_pkg::TICK_W-1:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(FIFO_DEPTH+1);

  logic [uart_pkg::TICK_W-1:0]    bit_ticks_r;
  logic                           in_fire, s1_go;
  logic                           s1_valid_r, out_valid_r;
  uart_pkg::out_item_t            s1_res_r, s1_res_nxt, out_data_r, out_data_nxt;

  uart_pkg::rx_push_t             rx_push;
  uart_pkg::drop_t                rx_drop;
  logic                           fifo_pop, fifo_full;
  logic [CW-1:0]                  fifo_count;
  logic [CW+uart_pkg::COUNT_W-1:0] count_ext;
  logic [uart_pkg::DATA_BITS-1:0] fifo_rd_q;
  logic                           tx_line_nxt, tx_busy_nxt, tx_acc;

  assign s1_go    = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r <= uart_pkg::RESET_BIT_TICKS;
    end else if (cfg_we) begin
      bit_ticks_r <= cfg_wdata;
    end
  end

  uart_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (in_fire),
    .pop_req       (in_data.rx_read),
    .push          (rx_push),
    .pop           (fifo_pop),
    .full_after_pop(fifo_full),
    .count         (fifo_count),
    .rd_q          (fifo_rd_q)
  );

  uart_rx u_rx (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (in_fire),
    .line     (in_data.rx_line),
    .bit_ticks(bit_ticks_r),
    .fifo_full(fifo_full),
    .push     (rx_push),
    .drop     (rx_drop)
  );

  uart_tx u_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (in_fire),
    .write    (in_data.tx_write),
    .data     (in_data.tx_data),
    .bit_ticks(bit_ticks_r),
    .line_nxt (tx_line_nxt),
    .busy_nxt (tx_busy_nxt),
    .accepted (tx_acc)
  );

  assign count_ext = {{uart_pkg::COUNT_W{1'b0}}, fifo_count};

  // The popped byte, read into the FIFO read register alongside stage one,
  // is merged into the result on its way to the output register.
  always_comb begin
    s1_res_nxt               = '0;
    s1_res_nxt.tx_line       = tx_line_nxt;
    s1_res_nxt.tx_busy       = tx_busy_nxt;
    s1_res_nxt.tx_accepted   = tx_acc;
    s1_res_nxt.rx_data_valid = fifo_pop;
    s1_res_nxt.rx_fifo_count = count_ext[uart_pkg::COUNT_W-1:0];
    s1_res_nxt.rx_drop       = rx_drop;
  end

  always_comb begin
    out_data_nxt         = s1_res_r;
    out_data_nxt.rx_data = s1_res_r.rx_data_valid ? fifo_rd_q : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res_r <= s1_res_nxt;
    end
    if (s1_go && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
